>>> rtl/core/skf_pkg.sv
package skf_pkg;

  localparam logic [1:0] FUNC_ROOT  = 2'd0;
  localparam logic [1:0] FUNC_JOINT = 2'd1;
  localparam logic [1:0] FUNC_BOX   = 2'd2;

  // tag that travels with one product through the multiply-accumulate pipe
  typedef struct packed {
    logic       vld;
    logic       first;
    logic       last;
    logic [3:0] tgt;
  } mac_tag_t;

endpackage

>>> rtl/core/skf_ram.sv
module skf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/skf_mac.sv
module skf_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  skf_pkg::mac_tag_t            iss,
  input  logic signed [31:0]           a,
  input  logic signed [31:0]           b,
  output skf_pkg::mac_tag_t            res,
  output logic signed [65-FRAC_BITS:0] sum
);

  localparam int RW = 64 - FRAC_BITS;
  localparam int SW = RW + 2;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  logic signed [31:0]    a_r, b_r;
  logic signed [63:0]    prod_r;
  skf_pkg::mac_tag_t     t0_r, t1_r, res_r;
  logic signed [SW-1:0]  acc_r, acc_nxt;
  logic signed [63:0]    prod_rnd;
  logic signed [RW-1:0]  rnd;

  // round to nearest, ties up, then floor shift
  always_comb begin
    prod_rnd = (prod_r + HALF) >>> FRAC_BITS;
    rnd      = prod_rnd[RW-1:0];
    if (t1_r.first) begin
      acc_nxt = SW'(rnd);
    end else begin
      acc_nxt = acc_r + SW'(rnd);
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a;
    b_r    <= b;
    prod_r <= a_r * b_r;
    if (t1_r.vld) begin
      acc_r <= acc_nxt;
    end
    if (!rst_n) begin
      t0_r  <= '0;
      t1_r  <= '0;
      res_r <= '0;
    end else begin
      t0_r      <= iss;
      t1_r      <= t0_r;
      res_r.vld <= t1_r.vld && t1_r.last;
      res_r.tgt <= t1_r.tgt;
      res_r.first <= 1'b0;
      res_r.last  <= 1'b0;
    end
  end

  assign res = res_r;
  assign sum = acc_r;

endmodule

>>> rtl/core/skeleton_forward_kinematics_unit.sv
// channel | ports                                       | direction
// in      | in_valid/in_ready, in_func .. in_size_z     | item in
// out     | out_valid/out_ready, out_bone .. out_last   | column result out
// cfg     | cfg_valid/cfg_ready, cfg_output_mode        | mode register write
// a root beat needs no multiply; joint and box time is set by the single shared
// multiplier: 64 products per matrix product, plus a parent fetch and, for a joint,
// a write of the joint memory
// one item is worked at a time; in_ready is high only while idle
// the out register holds a column until taken; the emit step waits on it
// reset (synchronous, rst_n low) loads the identity root and clears the bone count
module skeleton_forward_kinematics_unit #(
  parameter int MAX_BONES = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic signed [6:0]  in_link,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_vec_z,
  input  logic signed [31:0] in_quat_w,
  input  logic signed [31:0] in_quat_x,
  input  logic signed [31:0] in_quat_y,
  input  logic signed [31:0] in_quat_z,
  input  logic signed [31:0] in_size_x,
  input  logic signed [31:0] in_size_y,
  input  logic signed [31:0] in_size_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         out_bone,
  output logic [1:0]         out_column,
  output logic signed [31:0] out_entry0,
  output logic signed [31:0] out_entry1,
  output logic signed [31:0] out_entry2,
  output logic signed [31:0] out_entry3,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_output_mode
);

  localparam int BW    = $clog2(MAX_BONES);
  localparam int CW    = $clog2(MAX_BONES + 1);
  localparam int AW    = BW + 4;
  localparam int DEPTH = MAX_BONES * 16;
  localparam int SW    = 66 - FRAC_BITS;
  localparam int EW    = SW + 4;
  localparam logic signed [31:0] ONE = 32'(64'd1 << FRAC_BITS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_ROT   = 4'd2;
  localparam logic [3:0] S_PREP  = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_COPY  = 4'd5;
  localparam logic [3:0] S_STORE = 4'd6;
  localparam logic [3:0] S_EMIT  = 4'd7;

  localparam logic [1:0] PH_TRANS = 2'd0;
  localparam logic [1:0] PH_ROT   = 2'd1;
  localparam logic [1:0] PH_SCALE = 2'd2;

  function automatic logic signed [31:0] sat32(input logic signed [EW-1:0] v);
    logic signed [31:0] r;
    if (v > EW'(32'sh7fff_ffff)) begin
      r = 32'sh7fff_ffff;
    end else if (v < EW'(32'sh8000_0000)) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic [3:0]          state_r, state_nxt;
  logic [6:0]          cnt_r, cnt_nxt;
  logic [1:0]          phase_r, phase_nxt;
  logic [1:0]          col_r, col_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                mode_r, mode_nxt;
  logic                is_box_r, is_box_nxt;
  logic [BW-1:0]       idx_r, idx_nxt;
  logic [BW-1:0]       par_r, par_nxt;

  logic signed [31:0]  vx_r, vy_r, vz_r, qw_r, qx_r, qy_r, qz_r, sx_r, sy_r, sz_r;
  logic signed [31:0]  root_r [16];
  logic signed [31:0]  root_nxt [16];
  logic signed [31:0]  a_r [16];
  logic signed [31:0]  a_nxt [16];
  logic signed [31:0]  b_r [16];
  logic signed [31:0]  b_nxt [16];
  logic signed [31:0]  t_r [16];
  logic signed [31:0]  t_nxt [16];
  logic signed [SW-1:0] q_r [9];
  logic signed [SW-1:0] q_nxt [9];

  logic                out_valid_r, out_valid_nxt;
  logic [5:0]          out_bone_r, out_bone_nxt;
  logic [1:0]          out_column_r, out_column_nxt;
  logic signed [31:0]  out_e0_r, out_e0_nxt, out_e1_r, out_e1_nxt;
  logic signed [31:0]  out_e2_r, out_e2_nxt, out_e3_r, out_e3_nxt;
  logic                out_last_r, out_last_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [31:0]         ram_wdata, ram_rdata;

  skf_pkg::mac_tag_t   iss, res;
  logic signed [31:0]  mac_a, mac_b;
  logic signed [SW-1:0] mac_sum;

  logic                acc_in;
  logic [BW+5:0]       link_ext;
  logic [BW+5:0]       bone_ext;
  logic                parent_ok;
  logic [CW-1:0]       count_m1;
  logic signed [EW-1:0] qe [9];
  logic signed [EW-1:0] one_e;

  skf_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_joint_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  skf_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .iss   (iss),
    .a     (mac_a),
    .b     (mac_b),
    .res   (res),
    .sum   (mac_sum)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign acc_in    = in_valid && in_ready;
  assign link_ext  = {{BW{1'b0}}, in_link[5:0]};
  assign bone_ext  = {6'b0, idx_r};
  assign parent_ok = !in_link[6] && ({{CW{1'b0}}, in_link[5:0]} < {6'b0, count_r});
  assign count_m1  = count_r - CW'(1);
  assign one_e     = EW'(ONE);

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      qe[i] = EW'(q_r[i]);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    phase_nxt  = phase_r;
    col_nxt    = col_r;
    count_nxt  = count_r;
    mode_nxt   = mode_r;
    is_box_nxt = is_box_r;
    idx_nxt    = idx_r;
    par_nxt    = par_r;
    root_nxt   = root_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    t_nxt      = t_r;
    q_nxt      = q_r;

    out_valid_nxt  = out_valid_r && !out_ready;
    out_bone_nxt   = out_bone_r;
    out_column_nxt = out_column_r;
    out_e0_nxt     = out_e0_r;
    out_e1_nxt     = out_e1_r;
    out_e2_nxt     = out_e2_r;
    out_e3_nxt     = out_e3_r;
    out_last_nxt   = out_last_r;

    ram_we    = 1'b0;
    ram_waddr = {idx_r, cnt_r[3:0]};
    ram_wdata = a_r[0];
    ram_raddr = {par_r, cnt_r[3:0]};
    iss       = '0;
    mac_a     = a_r[{cnt_r[1:0], cnt_r[3:2]}];
    mac_b     = b_r[{cnt_r[5:4], cnt_r[1:0]}];

    if (cfg_valid) begin
      mode_nxt = cfg_output_mode;
    end

    case (state_r)
      S_IDLE: begin
        cnt_nxt   = '0;
        phase_nxt = PH_TRANS;
        if (acc_in) begin
          case (in_func)
            skf_pkg::FUNC_ROOT: begin
              root_nxt[{in_link[1:0], 2'd0}] = in_vec_x;
              root_nxt[{in_link[1:0], 2'd1}] = in_vec_y;
              root_nxt[{in_link[1:0], 2'd2}] = in_vec_z;
              root_nxt[{in_link[1:0], 2'd3}] = in_quat_w;
              count_nxt = '0;
            end
            skf_pkg::FUNC_JOINT: begin
              if (count_r < CW'(MAX_BONES)) begin
                is_box_nxt = 1'b0;
                idx_nxt    = count_r[BW-1:0];
                if (parent_ok) begin
                  par_nxt   = link_ext[BW-1:0];
                  state_nxt = S_LOAD;
                end else begin
                  a_nxt     = root_r;
                  state_nxt = S_ROT;
                end
              end
            end
            skf_pkg::FUNC_BOX: begin
              if (!mode_r) begin
                is_box_nxt = 1'b1;
                if (count_r != '0) begin
                  idx_nxt   = count_m1[BW-1:0];
                  par_nxt   = count_m1[BW-1:0];
                  state_nxt = S_LOAD;
                end else begin
                  idx_nxt   = '0;
                  a_nxt     = root_r;
                  state_nxt = S_ROT;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_LOAD: begin
        // read data is registered, so it arrives in the cycle after its address
        if (cnt_r != '0) begin
          a_nxt[cnt_r[3:0] - 4'd1] = ram_rdata;
        end
        if (cnt_r == 7'd16) begin
          cnt_nxt   = '0;
          state_nxt = S_ROT;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end

      S_ROT: begin
        if (cnt_r < 7'd9) begin
          iss.vld   = 1'b1;
          iss.first = 1'b1;
          iss.last  = 1'b1;
          iss.tgt   = cnt_r[3:0];
          cnt_nxt   = cnt_r + 7'd1;
          case (cnt_r[3:0])
            4'd0: begin mac_a = qx_r; mac_b = qx_r; end
            4'd1: begin mac_a = qy_r; mac_b = qy_r; end
            4'd2: begin mac_a = qz_r; mac_b = qz_r; end
            4'd3: begin mac_a = qx_r; mac_b = qy_r; end
            4'd4: begin mac_a = qx_r; mac_b = qz_r; end
            4'd5: begin mac_a = qy_r; mac_b = qz_r; end
            4'd6: begin mac_a = qw_r; mac_b = qx_r; end
            4'd7: begin mac_a = qw_r; mac_b = qy_r; end
            4'd8: begin mac_a = qw_r; mac_b = qz_r; end
            default: begin mac_a = qx_r; mac_b = qx_r; end
          endcase
        end
        if (res.vld && res.tgt < 4'd9) begin
          q_nxt[res.tgt] = mac_sum;
          if (res.tgt == 4'd8) begin
            state_nxt = S_PREP;
          end
        end
      end

      S_PREP: begin
        for (int i = 0; i < 16; i++) begin
          b_nxt[i] = (i == 0 || i == 5 || i == 10 || i == 15) ? ONE : 32'sd0;
        end
        case (phase_r)
          PH_TRANS: begin
            b_nxt[12] = vx_r;
            b_nxt[13] = vy_r;
            b_nxt[14] = vz_r;
          end
          PH_ROT: begin
            b_nxt[0]  = sat32(one_e - ((qe[1] + qe[2]) <<< 1));
            b_nxt[1]  = sat32((qe[3] + qe[8]) <<< 1);
            b_nxt[2]  = sat32((qe[4] - qe[7]) <<< 1);
            b_nxt[4]  = sat32((qe[3] - qe[8]) <<< 1);
            b_nxt[5]  = sat32(one_e - ((qe[0] + qe[2]) <<< 1));
            b_nxt[6]  = sat32((qe[5] + qe[6]) <<< 1);
            b_nxt[8]  = sat32((qe[4] + qe[7]) <<< 1);
            b_nxt[9]  = sat32((qe[5] - qe[6]) <<< 1);
            b_nxt[10] = sat32(one_e - ((qe[0] + qe[1]) <<< 1));
          end
          default: begin
            b_nxt[0]  = sx_r;
            b_nxt[5]  = sy_r;
            b_nxt[10] = sz_r;
          end
        endcase
        cnt_nxt   = '0;
        state_nxt = S_MUL;
      end

      S_MUL: begin
        // cnt = {col, row, k}
        if (cnt_r < 7'd64) begin
          iss.vld   = 1'b1;
          iss.first = (cnt_r[1:0] == 2'd0);
          iss.last  = (cnt_r[1:0] == 2'd3);
          iss.tgt   = {cnt_r[5:4], cnt_r[3:2]};
          cnt_nxt   = cnt_r + 7'd1;
        end
        if (res.vld) begin
          t_nxt[res.tgt] = sat32(EW'(mac_sum));
          if (res.tgt == 4'd15) begin
            state_nxt = S_COPY;
          end
        end
      end

      S_COPY: begin
        a_nxt   = t_r;
        cnt_nxt = '0;
        col_nxt = '0;
        if (phase_r == (is_box_r ? PH_SCALE : PH_ROT)) begin
          state_nxt = is_box_r ? S_EMIT : S_STORE;
        end else begin
          phase_nxt = phase_r + 2'd1;
          state_nxt = S_PREP;
        end
      end

      S_STORE: begin
        // rotate the matrix past entry 0 so it is intact afterwards
        ram_we = 1'b1;
        for (int i = 0; i < 16; i++) begin
          a_nxt[i] = a_r[(i + 1) % 16];
        end
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r[3:0] == 4'd15) begin
          count_nxt = count_r + CW'(1);
          state_nxt = mode_r ? S_EMIT : S_IDLE;
        end
      end

      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_bone_nxt   = bone_ext[5:0];
          out_column_nxt = col_r;
          out_e0_nxt     = a_r[0];
          out_e1_nxt     = a_r[1];
          out_e2_nxt     = a_r[2];
          out_e3_nxt     = a_r[3];
          out_last_nxt   = (col_r == 2'd3);
          for (int i = 0; i < 16; i++) begin
            a_nxt[i] = a_r[(i + 4) % 16];
          end
          col_nxt = col_r + 2'd1;
          if (col_r == 2'd3) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    phase_r  <= phase_nxt;
    col_r    <= col_nxt;
    is_box_r <= is_box_nxt;
    idx_r    <= idx_nxt;
    par_r    <= par_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    t_r      <= t_nxt;
    q_r      <= q_nxt;
    out_bone_r   <= out_bone_nxt;
    out_column_r <= out_column_nxt;
    out_e0_r     <= out_e0_nxt;
    out_e1_r     <= out_e1_nxt;
    out_e2_r     <= out_e2_nxt;
    out_e3_r     <= out_e3_nxt;
    out_last_r   <= out_last_nxt;
    if (acc_in) begin
      vx_r <= in_vec_x;
      vy_r <= in_vec_y;
      vz_r <= in_vec_z;
      qw_r <= in_quat_w;
      qx_r <= in_quat_x;
      qy_r <= in_quat_y;
      qz_r <= in_quat_z;
      sx_r <= in_size_x;
      sy_r <= in_size_y;
      sz_r <= in_size_z;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        root_r[i] <= (i == 0 || i == 5 || i == 10 || i == 15) ? ONE : 32'sd0;
      end
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
      root_r      <= root_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_bone   = out_bone_r;
  assign out_column = out_column_r;
  assign out_entry0 = out_e0_r;
  assign out_entry1 = out_e1_r;
  assign out_entry2 = out_e2_r;
  assign out_entry3 = out_e3_r;
  assign out_last   = out_last_r;

endmodule
